// ===== rtl/nsqrt_pkg.sv =====
// shared types and constants for the newton square root block
// no dependencies; used by nsqrt_ctrl, nsqrt_dpath and newton_square_root
package nsqrt_pkg;

  localparam int unsigned VALUE_W = 32;  // signed operand width
  localparam int unsigned ROOT_W  = 31;  // unsigned root width
  localparam int unsigned TOL_W   = 16;  // tolerance register width
  localparam int unsigned DATA_W  = 32;  // apb data width
  localparam int unsigned ADDR_W  = 3;   // apb address width

  // register index taken from paddr
  localparam logic REG_TOLERANCE = 1'b0;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the operand
    logic div_init;  // set up a division by the current guess
    logic div_step;  // one restoring division step
    logic update;    // next guess from guess and quotient
    logic advance;   // next guess becomes current guess
    logic fin_bad;   // finish: negative operand
    logic fin_raw;   // finish: operand returned unchanged
    logic fin_iter;  // finish: last computed guess
    logic stuck;     // finish with the cap flag
  } nsqrt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic neg;       // operand is negative
    logic trivial;   // operand is zero or exactly one
    logic close;     // successive guesses within tolerance
  } nsqrt_status_t;

endpackage

// ===== rtl/nsqrt_ctrl.sv =====
// controller state machine of the newton square root block
// depends on nsqrt_pkg for the command and status structs
module nsqrt_ctrl #(
  parameter int unsigned MAX_ITER  = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  nsqrt_pkg::nsqrt_status_t status_i,
  output nsqrt_pkg::nsqrt_cmd_t    cmd_o,
  output logic                   busy_o
);

  localparam int unsigned DW  = nsqrt_pkg::ROOT_W + FRAC_BITS;
  localparam int unsigned SCW = $clog2(DW + 1);
  localparam int unsigned IW  = $clog2(MAX_ITER + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [SCW-1:0] step_q, step_d;
  logic [IW-1:0]  iter_q, iter_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    iter_d  = iter_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (status_i.neg) begin
          cmd_o.fin_bad = 1'b1;
          state_d       = S_IDLE;
        end else if (status_i.trivial) begin
          cmd_o.fin_raw = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          step_d         = '0;
          iter_d         = IW'(1);
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + SCW'(1);
        if (step_q == SCW'(DW - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        priority if (status_i.close) begin
          cmd_o.fin_iter = 1'b1;
          state_d        = S_IDLE;
        end else if (iter_q >= IW'(MAX_ITER)) begin
          cmd_o.fin_iter = 1'b1;
          cmd_o.stuck    = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.advance  = 1'b1;
          cmd_o.div_init = 1'b1;
          step_d         = '0;
          iter_d         = iter_q + IW'(1);
          state_d        = S_DIV;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      iter_q  <= iter_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/nsqrt_dpath.sv =====
// datapath of the newton square root block: operand, guesses,
// serial restoring divider and result registers; depends on nsqrt_pkg
module nsqrt_dpath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  nsqrt_pkg::nsqrt_cmd_t                cmd_i,
  output nsqrt_pkg::nsqrt_status_t             status_o,
  input  logic signed [nsqrt_pkg::VALUE_W-1:0] value_i,
  input  logic        [nsqrt_pkg::TOL_W-1:0]   tol_i,
  output logic                                 done_o,
  output logic        [nsqrt_pkg::ROOT_W-1:0]  root_o,
  output logic                                 invalid_o,
  output logic                                 not_converged_o
);

  localparam int unsigned RW = nsqrt_pkg::ROOT_W;
  localparam int unsigned VW = nsqrt_pkg::VALUE_W;
  localparam int unsigned DW = RW + FRAC_BITS;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic [VW-1:0] raw_q;
  logic [DW-1:0] cur_q, nxt_q;
  logic [DW-1:0] dvd_q, dvs_q, rem_q, quo_q;
  logic [RW-1:0] root_q;
  logic          done_q, invalid_q, stuck_q;

  logic [DW-1:0] scaled;
  logic [DW-1:0] dvs_src;
  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   sum;
  logic [DW-1:0] diff;
  logic          sat;

  assign scaled  = {raw_q[RW-1:0], {FRAC_BITS{1'b0}}};
  assign dvs_src = cmd_i.advance ? nxt_q : cur_q;
  // one restoring step: shift in the next dividend bit and try to subtract
  assign trial   = {rem_q, dvd_q[DW-1]};
  assign fits    = (trial >= {1'b0, dvs_q});
  assign sum     = {1'b0, cur_q} + {1'b0, quo_q};
  assign diff    = (cur_q > nxt_q) ? (cur_q - nxt_q) : (nxt_q - cur_q);
  assign sat     = |nxt_q[DW-1:RW];

  assign status_o.neg     = raw_q[VW-1];
  assign status_o.trivial = (raw_q == '0) || (raw_q == ONE);
  assign status_o.close   = (diff <= DW'(tol_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q <= value_i;
      cur_q <= DW'(value_i[RW-1:0]);
    end
    if (cmd_i.advance) begin
      cur_q <= nxt_q;
    end
    if (cmd_i.div_init) begin
      dvd_q <= scaled;
      dvs_q <= (dvs_src == '0) ? DW'(1) : dvs_src;
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
    if (cmd_i.update) begin
      nxt_q <= sum[DW:1];
    end
    if (cmd_i.fin_bad) begin
      root_q    <= '0;
      invalid_q <= 1'b1;
      stuck_q   <= 1'b0;
    end
    if (cmd_i.fin_raw) begin
      root_q    <= raw_q[RW-1:0];
      invalid_q <= 1'b0;
      stuck_q   <= 1'b0;
    end
    if (cmd_i.fin_iter) begin
      root_q    <= sat ? {RW{1'b1}} : nxt_q[RW-1:0];
      invalid_q <= 1'b0;
      stuck_q   <= cmd_i.stuck;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin_bad | cmd_i.fin_raw | cmd_i.fin_iter;
    end
  end

  assign done_o          = done_q;
  assign root_o          = root_q;
  assign invalid_o       = invalid_q;
  assign not_converged_o = stuck_q;

endmodule

// ===== rtl/newton_square_root.sv =====
// top level of the newton square root block: apb tolerance register,
// controller and datapath; depends on nsqrt_pkg, nsqrt_ctrl, nsqrt_dpath

// Fixed-point square root by Newton's iteration. An item (a signed Q16.16
// value on value_i) is taken when start is high and busy is low; busy stays
// high until the result is ready. The result shows on root_o, invalid_o and
// not_converged_o when done_o is high for a single cycle, and must be caught
// then; it stays in the result registers until the next item finishes. A
// negative operand returns a zero root with invalid_o set, and zero or
// exactly 1.0 come back unchanged. Otherwise the first guess is the operand
// and each Newton step divides the operand (shifted up by FRAC_BITS) by the
// guess in a one-bit-per-cycle restoring divider, then forms the next guess
// and checks it against the tolerance; an item runs at most MAX_ITER steps.
// busy drops in the cycle that done_o is high, so the next item can start
// right then. When MAX_ITER steps pass without the guesses settling within
// the tolerance, not_converged_o is set and the last guess is returned. The
// tolerance register sits at byte address 0 (reset value 1 lsb); the user
// must write it only while the block is idle, and the block itself does not
// enforce this.
module newton_square_root #(
  parameter int unsigned MAX_ITER  = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [nsqrt_pkg::VALUE_W-1:0] value_i,
  // result strobe
  output logic                                 done_o,
  output logic        [nsqrt_pkg::ROOT_W-1:0]  root_o,
  output logic                                 invalid_o,
  output logic                                 not_converged_o,
  // apb configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [nsqrt_pkg::ADDR_W-1:0]  paddr,
  input  logic        [nsqrt_pkg::DATA_W-1:0]  pwdata,
  output logic        [nsqrt_pkg::DATA_W-1:0]  prdata,
  output logic                                 pready
);

  localparam int unsigned TW = nsqrt_pkg::TOL_W;

  nsqrt_pkg::nsqrt_cmd_t    cmd;
  nsqrt_pkg::nsqrt_status_t status;

  logic [TW-1:0] tol_q, tol_d;
  logic          wr_en;
  logic          start_ok;

  // apb: zero wait states; paddr[2] picks the register, only index 0 exists
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    tol_d = tol_q;
    if (wr_en && (paddr[2] == nsqrt_pkg::REG_TOLERANCE)) begin
      tol_d = pwdata[TW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= nsqrt_pkg::TOL_RESET;
    end else begin
      tol_q <= tol_d;
    end
  end

  assign prdata = (paddr[2] == nsqrt_pkg::REG_TOLERANCE) ?
                  nsqrt_pkg::DATA_W'(tol_q) : '0;

  // an item is taken only when the controller is idle
  assign start_ok = start && !busy;

  nsqrt_ctrl #(
    .MAX_ITER  (MAX_ITER),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_ok),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  nsqrt_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_i         (value_i),
    .tol_i           (tol_q),
    .done_o          (done_o),
    .root_o          (root_o),
    .invalid_o       (invalid_o),
    .not_converged_o (not_converged_o)
  );

endmodule
